FILE: sv/rsenc_pkg.sv
package rsenc_pkg;

  // Field and configuration widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned EccLenW = 6;

  // Largest parity length any build may ask for
  localparam int unsigned GenMax = 63;

  // Default build size and register reset value
  localparam int unsigned MaxEccDefault = 32;
  localparam logic [EccLenW-1:0] EccLenReset = 6'd10;

  // Field polynomial 0x11D with the x^8 term implied, primitive element 2
  localparam logic [ByteW-1:0] GfPolyLow = 8'h1D;
  localparam logic [ByteW-1:0] GfRoot    = 8'h02;

  typedef logic [ByteW-1:0] gf_t;
  typedef gf_t [GenMax-1:0] gen_full_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } in_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             is_parity;
    logic             last;
  } out_t;

  // GF(2^8) multiply, one shift-and-add step per bit of b
  function automatic gf_t gf_mul(input gf_t a, input gf_t b);
    gf_t acc;
    acc = '0;
    for (int bit_idx = ByteW - 1; bit_idx >= 0; bit_idx--) begin
      acc = {acc[ByteW-2:0], 1'b0} ^ (acc[ByteW-1] ? GfPolyLow : gf_t'(0));
      acc = acc ^ (b[bit_idx] ? a : gf_t'(0));
    end
    return acc;
  endfunction

  // Generator coefficients for degree n, leading one dropped,
  // entry 0 is the highest remaining coefficient
  function automatic gen_full_t gf_gen(input int n);
    gen_full_t g;
    gf_t       root;
    g    = '0;
    root = 8'h01;
    g[n-1] = 8'h01;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        g[j] = gf_mul(g[j], root);
        if (j + 1 < n) begin
          g[j] = g[j] ^ g[j+1];
        end
      end
      root = gf_mul(root, GfRoot);
    end
    return g;
  endfunction

endpackage

FILE: sv/reed_solomon_parity_encoder_top.sv
// Systematic Reed-Solomon encoder, GF(2^8), field polynomial 0x11D.
// Input channel (in_valid_i/in_ready_o, in_data_i): one message byte per
// word, most significant coefficient first; last_byte marks the end.
// Output channel (out_valid_o/out_ready_i, out_data_o): every message byte
// comes back unchanged with is_parity low; after the last one follow n
// parity words, highest coefficient first, the final one flagged by last.
// n is sampled from the ecc_len register (cfg_we_i/cfg_wdata_i) at the first
// byte of each message: zero acts as 1, values above MAX_ECC saturate.
// A byte passes from the input register on to the output register.
// Throughput: one byte per cycle while the receiver keeps up; after a last
// byte the input stage holds while the n parity words drain
// through the single output register, one per cycle.
// A stalled receiver holds the output word; the input register still takes
// one more word, then in_ready_o drops until the output moves again.
// Reset empties both registers, clears the remainder, sets ecc_len to 10
// and makes the next byte the start of a message.
module reed_solomon_parity_encoder_top #(
  parameter int unsigned MAX_ECC = rsenc_pkg::MaxEccDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  rsenc_pkg::in_t                 in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output rsenc_pkg::out_t                out_data_o,
  input  logic                           cfg_we_i,
  input  logic [rsenc_pkg::EccLenW-1:0]  cfg_wdata_i
);
  import rsenc_pkg::*;

  localparam int unsigned DegW = $clog2(MAX_ECC + 1);

  typedef gf_t [MAX_ECC-1:0] gen_t;

  // Configuration register
  logic [EccLenW-1:0] ecc_q;

  // Input stage
  logic            in_vld_q;
  in_t             in_q;
  logic            in_start_q;
  logic [DegW-1:0] in_deg_q;
  logic            in_msg_q;

  // Division state
  gen_t            gen_q;
  gen_t            rem_q;
  logic [DegW-1:0] deg_q;
  logic [DegW-1:0] par_left_q;

  // Output stage
  logic out_vld_q;
  out_t out_q;

  logic            in_acc;
  logic            out_free;
  logic            advance;
  logic            par_load;
  logic [DegW-1:0] eff_deg;
  gen_t            gen_tab [MAX_ECC+1];
  gen_t            gen_cur;
  gen_t            rem_upd;
  gen_t            rem_shift;
  gf_t             factor;

  // Build the generator table at elaboration, one row per degree
  for (genvar g = 0; g <= MAX_ECC; g++) begin : g_gen_tab
    localparam int        Deg     = (g == 0) ? 1 : g;
    localparam gen_full_t GenFull = gf_gen(Deg);
    assign gen_tab[g] = GenFull[MAX_ECC-1:0];
  end

  // Handshake and stage control
  assign out_free   = !out_vld_q || out_ready_i;
  assign par_load   = (par_left_q != '0) && out_free;
  assign advance    = in_vld_q && out_free && (par_left_q == '0);
  assign in_ready_o = !in_vld_q || advance;
  assign in_acc     = in_valid_i && in_ready_o;

  // Saturate the configured parity length and map zero to one
  always_comb begin
    if (ecc_q == '0) begin
      eff_deg = DegW'(1);
    end else if (ecc_q > EccLenW'(MAX_ECC)) begin
      eff_deg = DegW'(MAX_ECC);
    end else begin
      eff_deg = DegW'(ecc_q);
    end
  end

  // One division step and the plain shift used while draining parity
  always_comb begin
    gen_cur = in_start_q ? gen_tab[in_deg_q] : gen_q;
    factor  = in_q.data_byte ^ rem_q[0];
    for (int i = 0; i < MAX_ECC; i++) begin
      rem_shift[i] = (i + 1 < MAX_ECC) ? rem_q[(i + 1) % MAX_ECC] : gf_t'(0);
      rem_upd[i]   = rem_shift[i] ^ gf_mul(gen_cur[i], factor);
    end
  end

  // Hold the configured parity length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecc_q <= EccLenReset;
    end else if (cfg_we_i) begin
      ecc_q <= cfg_wdata_i;
    end
  end

  // Capture input words and track message boundaries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      in_msg_q <= 1'b0;
    end else begin
      if (in_acc) begin
        in_vld_q <= 1'b1;
        in_msg_q <= !in_data_i.last_byte;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q       <= in_data_i;
      in_start_q <= !in_msg_q;
      in_deg_q   <= eff_deg;
    end
  end

  // Advance the remainder and count out the parity words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q      <= '0;
      par_left_q <= '0;
      deg_q      <= DegW'(1);
    end else if (par_load) begin
      rem_q      <= rem_shift;
      par_left_q <= par_left_q - DegW'(1);
    end else if (advance) begin
      rem_q <= rem_upd;
      if (in_start_q) begin
        deg_q <= in_deg_q;
      end
      if (in_q.last_byte) begin
        par_left_q <= in_start_q ? in_deg_q : deg_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_start_q) begin
      gen_q <= gen_cur;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (par_load || advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (par_load) begin
      out_q.out_byte  <= rem_q[0];
      out_q.is_parity <= 1'b1;
      out_q.last      <= (par_left_q == DegW'(1));
    end else if (advance) begin
      out_q.out_byte  <= in_q.data_byte;
      out_q.is_parity <= 1'b0;
      out_q.last      <= 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

FILE: sv/rsenc_checker.sv
module rsenc_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input rsenc_pkg::out_t out_data_o
);
  import rsenc_pkg::*;

  logic out_acc;
  logic par_run_q;

  assign out_acc = out_valid_o && out_ready_i;

  // Track a parity run between its first accepted word and the flagged last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_run_q <= 1'b0;
    end else if (out_acc && out_data_o.is_parity) begin
      par_run_q <= !out_data_o.last;
    end
  end

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // The final flag only rides on a parity word
  a_last_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> out_data_o.is_parity)
    else $error("last flag on a data word");

  // No data word cuts into a parity run
  a_par_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && par_run_q |-> out_data_o.is_parity)
    else $error("data word inside a parity run");

  // Input only backs up behind a full output register
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

endmodule

bind reed_solomon_parity_encoder_top rsenc_checker u_rsenc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rsenc_pkg::*;

  localparam int MaxEcc = MaxEccDefault;
  localparam int unsigned CycleLimit = 400000;
  localparam int RandBytes = 200;

  typedef enum logic {RowByte, RowCfg} row_kind_e;

  // One step of the directed script: a message byte or an ecc_len write.
  // A typed row carries the parity value every parity word must show.
  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] val;
    logic       fin;
    logic       typed;
    gf_t        par;
  } row_t;

  localparam int NumRows = 25;
  localparam row_t Script [NumRows] = '{
    // all-zero message at the reset length gives all-zero parity
    '{RowByte, 8'h00, 1'b0, 1'b0, 8'h00},
    '{RowByte, 8'h00, 1'b0, 1'b0, 8'h00},
    '{RowByte, 8'h00, 1'b1, 1'b1, 8'h00},
    // length 1: g(x) = x + 1, parity is the xor of all message bytes
    '{RowCfg,  8'd1,  1'b0, 1'b0, 8'h00},
    '{RowByte, 8'hFF, 1'b1, 1'b1, 8'hFF},
    '{RowByte, 8'h00, 1'b1, 1'b1, 8'h00},
    // zero acts as length 1
    '{RowCfg,  8'd0,  1'b0, 1'b0, 8'h00},
    '{RowByte, 8'h0F, 1'b0, 1'b0, 8'h00},
    '{RowByte, 8'hF0, 1'b1, 1'b1, 8'hFF},
    // largest length
    '{RowCfg,  8'd32, 1'b0, 1'b0, 8'h00},
    '{RowByte, 8'hFF, 1'b0, 1'b0, 8'h00},
    '{RowByte, 8'h00, 1'b0, 1'b0, 8'h00},
    '{RowByte, 8'h80, 1'b0, 1'b0, 8'h00},
    '{RowByte, 8'h01, 1'b1, 1'b0, 8'h00},
    // lengths above the maximum saturate
    '{RowCfg,  8'd63, 1'b0, 1'b0, 8'h00},
    '{RowByte, 8'h55, 1'b0, 1'b0, 8'h00},
    '{RowByte, 8'hAA, 1'b1, 1'b0, 8'h00},
    '{RowCfg,  8'd33, 1'b0, 1'b0, 8'h00},
    '{RowByte, 8'h7E, 1'b1, 1'b0, 8'h00},
    // a write inside a message waits for the next message
    '{RowCfg,  8'd5,  1'b0, 1'b0, 8'h00},
    '{RowByte, 8'h12, 1'b0, 1'b0, 8'h00},
    '{RowByte, 8'h34, 1'b0, 1'b0, 8'h00},
    '{RowCfg,  8'd1,  1'b0, 1'b0, 8'h00},
    '{RowByte, 8'h56, 1'b1, 1'b0, 8'h00},
    '{RowByte, 8'h9C, 1'b1, 1'b1, 8'h9C}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  in_t                in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  out_t               out_data_o;
  logic               cfg_we_i;
  logic [EccLenW-1:0] cfg_wdata_i;

  // Encoder state as the testbench tracks it
  logic [EccLenW-1:0] ecc_cfg;
  gf_t                remainder [MaxEcc];
  gf_t                gen_poly [MaxEcc];
  int                 msg_deg;
  bit                 msg_open;
  out_t               codeword_q [$];

  bit                 burst_mode;
  int                 err_cnt = 0;
  int unsigned        cycle_cnt = 0;

  reed_solomon_parity_encoder_top #(
    .MAX_ECC(MaxEcc)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // GF(2^8) product, walking b from its low bit while doubling a
  function automatic gf_t gf_product(input gf_t a, input gf_t b);
    gf_t acc;
    gf_t x;
    acc = '0;
    x = a;
    for (int k = 0; k < ByteW; k++) begin
      if (b[k]) acc ^= x;
      x = x[ByteW-1] ? ({x[ByteW-2:0], 1'b0} ^ GfPolyLow) : {x[ByteW-2:0], 1'b0};
    end
    return acc;
  endfunction

  // Expand (x + 1)(x + 2)...(x + 2^(n-1)) in ascending powers, then store
  // the non-leading coefficients highest power first
  function automatic void build_gen_poly(input int n);
    gf_t coef [MaxEcc+1];
    gf_t root;
    for (int k = 0; k <= MaxEcc; k++) coef[k] = '0;
    coef[0] = 8'h01;
    root = 8'h01;
    for (int i = 0; i < n; i++) begin
      for (int k = i + 1; k > 0; k--) coef[k] = coef[k-1] ^ gf_product(coef[k], root);
      coef[0] = gf_product(coef[0], root);
      root = gf_product(root, GfRoot);
    end
    for (int j = 0; j < MaxEcc; j++) begin
      if (j < n) gen_poly[j] = coef[n-1-j];
      else gen_poly[j] = '0;
    end
  endfunction

  // Advance the division by one byte and queue the words it produces
  function automatic void encode_byte(input in_t w);
    gf_t  factor;
    out_t due;
    if (!msg_open) begin
      if (ecc_cfg == 0) msg_deg = 1;
      else if (ecc_cfg > MaxEcc) msg_deg = MaxEcc;
      else msg_deg = int'(ecc_cfg);
      build_gen_poly(msg_deg);
      for (int k = 0; k < MaxEcc; k++) remainder[k] = '0;
      msg_open = 1'b1;
    end
    factor = w.data_byte ^ remainder[0];
    for (int k = 0; k < msg_deg - 1; k++) remainder[k] = remainder[k+1];
    remainder[msg_deg-1] = '0;
    for (int k = 0; k < msg_deg; k++) remainder[k] ^= gf_product(gen_poly[k], factor);
    due = '{out_byte: w.data_byte, is_parity: 1'b0, last: 1'b0};
    codeword_q = {codeword_q, due};
    if (w.last_byte) begin
      for (int k = 0; k < msg_deg; k++) begin
        due = '{out_byte: remainder[k], is_parity: 1'b1, last: (k == msg_deg - 1)};
        codeword_q = {codeword_q, due};
      end
      msg_open = 1'b0;
    end
  endfunction

  // Compare one output word with the oldest word still due
  function automatic void check_word(input out_t got);
    out_t want;
    if (codeword_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= 10) begin
        $display("unexpected word: byte %02h parity %0b last %0b",
                 got.out_byte, got.is_parity, got.last);
      end
    end else begin
      want = codeword_q.pop_front();
      if (got.out_byte !== want.out_byte || got.is_parity !== want.is_parity ||
          got.last !== want.last) begin
        err_cnt++;
        if (err_cnt <= 10) begin
          $display("mismatch: want %02h/%0b/%0b, got %02h/%0b/%0b",
                   want.out_byte, want.is_parity, want.last,
                   got.out_byte, got.is_parity, got.last);
        end
      end
    end
  endfunction

  // Offer one byte after a random gap, none in burst mode; hold it until it is taken
  task automatic send_word(input in_t w, input bit typed, input gf_t par);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(8);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    encode_byte(w);
    if (typed && w.last_byte) begin
      for (int k = 1; k <= msg_deg; k++) codeword_q[codeword_q.size() - k].out_byte = par;
    end
  endtask

  // Drain the block, then write ecc_len
  task automatic write_ecc(input logic [EccLenW-1:0] v);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (codeword_q.size() != 0) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    ecc_cfg = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Stimulus: directed script, then random messages in phases
  initial begin
    int                 sent;
    int                 msgs;
    int                 len;
    in_t                w;
    logic [EccLenW-1:0] ecc_pick;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    burst_mode  = 1'b0;
    ecc_cfg     = EccLenReset;
    msg_open    = 1'b0;
    msg_deg     = 1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (Script[r]) begin
      if (Script[r].kind == RowCfg) begin
        write_ecc(Script[r].val[EccLenW-1:0]);
      end else begin
        w.data_byte = Script[r].val;
        w.last_byte = Script[r].fin;
        send_word(w, Script[r].typed, Script[r].par);
      end
    end

    sent = 0;
    while (sent < RandBytes) begin
      case ($urandom_range(9))
        0: ecc_pick = '0;
        1: ecc_pick = EccLenW'(1);
        2: ecc_pick = EccLenW'(MaxEcc);
        3: ecc_pick = EccLenW'($urandom_range(2 ** EccLenW - 1, MaxEcc + 1));
        default: ecc_pick = EccLenW'($urandom_range(MaxEcc, 1));
      endcase
      write_ecc(ecc_pick);
      burst_mode = ($urandom_range(3) == 0);
      msgs = $urandom_range(4, 1);
      repeat (msgs) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(24, 9) : $urandom_range(6, 1);
        for (int b = 0; b < len; b++) begin
          w.data_byte = 8'($urandom);
          w.last_byte = (b == len - 1);
          send_word(w, 1'b0, '0);
          sent++;
        end
      end
    end

    // Drop valid, wait for the last words, then idle before finishing
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (codeword_q.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Receiver: stall a random number of cycles before each word, none in burst mode
  initial begin
    int stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(8);
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Check every word taken at the output
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_word(out_data_o);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

endmodule
